// ----- sv/md5_pkg.sv -----
// md5 package: item types, initial chaining values and round tables
// no dependencies
package md5_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } out_item_t;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LEN_POS = 6'd56;
  localparam logic [3:0]  LEN_LO_WORD = 4'd14;
  localparam logic [3:0]  LEN_HI_WORD = 4'd15;
  localparam logic [5:0]  LAST_ROUND = 6'd63;

  function automatic logic [31:0] rnd_const(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
      6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
      6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
      6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // message word used by round i
  function automatic logic [3:0] msg_idx(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(i[3:0] * 4'd5 + 4'd1);
      2'd2: g = 4'(i[3:0] * 4'd3 + 4'd5);
      default: g = 4'(i[3:0] * 4'd7);
    endcase
    return g;
  endfunction

endpackage

// ----- sv/md5_hash_engine.sv -----
// md5 engine top level: byte packing, block memory, round sequencer, digest output
// depends on md5_pkg
// throughput: one byte item per cycle while idle; no input is taken while a block's rounds run
// rounds run one per cycle from the block memory, whose registered read is set to the next round's word
// digest words come out one per accepted result item, four per message
// reset (rst_n low, synchronous) loads the initial chaining values and empties the block
module md5_hash_engine import md5_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [2:0] {S_IDLE, S_PAD, S_RD, S_RND, S_FIN, S_OUT} state_t;

  state_t      state_r;
  logic [31:0] chain_r [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [63:0] count_r;
  logic [31:0] acc_r;
  logic [15:0] word_vld_r;
  logic [5:0]  rnd_r;
  logic        eom_r, pad_done_r, len_r;
  logic [1:0]  out_idx_r;

  logic [31:0] blk_mem [16];
  logic [31:0] rd_data_r;
  logic        rd_vld_r;
  logic [3:0]  rd_addr_r;

  logic        mem_we;
  logic [3:0]  mem_waddr, mem_raddr;
  logic [31:0] mem_wdata;

  logic [5:0]  pos;
  logic [4:0]  bsh;
  logic [31:0] byte_word, pad_word;
  logic [63:0] bits;
  logic [31:0] m, f, sum, b_nxt;

  assign pos = count_r[5:0];
  assign bsh = {pos[1:0], 3'b000};
  assign byte_word = ((pos[1:0] == 2'd0) ? 32'h0 : acc_r) | ({24'h0, in_data.data_byte} << bsh);
  assign pad_word  = ((pos[1:0] == 2'd0) ? 32'h0 : acc_r) | ({24'h0, PAD_BYTE} << bsh);
  assign bits = {count_r[60:0], 3'b000};

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data.digest_word = chain_r[out_idx_r];
  assign out_data.word_index  = out_idx_r;
  assign out_data.last_word   = (out_idx_r == 2'd3);

  // writes only while idle or padding; the registered read runs every cycle at the next round's word
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos[5:2];
    mem_wdata = byte_word;
    mem_raddr = msg_idx(6'(rnd_r + 6'd1));
    case (state_r)
      S_IDLE: mem_we = in_valid && in_data.byte_valid;
      S_PAD: begin
        mem_we    = 1'b1;
        mem_wdata = pad_word;
      end
      S_RD: mem_raddr = msg_idx(6'd0);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      blk_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= blk_mem[mem_raddr];
    rd_vld_r  <= word_vld_r[mem_raddr];
    rd_addr_r <= mem_raddr;
  end

  // round datapath, unwritten words read as zero, length sits in the last two words
  always_comb begin
    m = rd_vld_r ? rd_data_r : 32'h0;
    if (len_r && rd_addr_r == LEN_LO_WORD) begin
      m = bits[31:0];
    end else if (len_r && rd_addr_r == LEN_HI_WORD) begin
      m = bits[63:32];
    end
    case (rnd_r[5:4])
      2'd0: f = (b_r & c_r) | (~b_r & d_r);
      2'd1: f = (d_r & b_r) | (~d_r & c_r);
      2'd2: f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    sum   = a_r + f + rnd_const(rnd_r) + m;
    b_nxt = b_r + 32'(({sum, sum} << rot_amt(rnd_r)) >> 32);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      chain_r[0] <= INIT_A;
      chain_r[1] <= INIT_B;
      chain_r[2] <= INIT_C;
      chain_r[3] <= INIT_D;
      count_r    <= 64'h0;
      word_vld_r <= 16'h0;
      rnd_r      <= 6'd0;
      eom_r      <= 1'b0;
      pad_done_r <= 1'b0;
      len_r      <= 1'b0;
      out_idx_r  <= 2'd0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            eom_r      <= in_data.end_of_message;
            pad_done_r <= 1'b0;
            len_r      <= 1'b0;
            if (in_data.byte_valid) begin
              acc_r              <= byte_word;
              word_vld_r[pos[5:2]] <= 1'b1;
              count_r            <= count_r + 64'd1;
            end
            if (in_data.byte_valid && pos == LAST_ROUND) begin
              state_r <= S_RD;
            end else if (in_data.end_of_message) begin
              state_r <= S_PAD;
            end
          end
        end
        S_PAD: begin
          word_vld_r[pos[5:2]] <= 1'b1;
          pad_done_r <= 1'b1;
          len_r      <= (pos < LEN_POS);
          state_r    <= S_RD;
        end
        S_RD: begin
          a_r     <= chain_r[0];
          b_r     <= chain_r[1];
          c_r     <= chain_r[2];
          d_r     <= chain_r[3];
          rnd_r   <= 6'd0;
          state_r <= S_RND;
        end
        S_RND: begin
          a_r   <= d_r;
          d_r   <= c_r;
          c_r   <= b_r;
          b_r   <= b_nxt;
          rnd_r <= 6'(rnd_r + 6'd1);
          if (rnd_r == LAST_ROUND) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          chain_r[0] <= chain_r[0] + a_r;
          chain_r[1] <= chain_r[1] + b_r;
          chain_r[2] <= chain_r[2] + c_r;
          chain_r[3] <= chain_r[3] + d_r;
          word_vld_r <= 16'h0;
          if (len_r) begin
            out_idx_r <= 2'd0;
            state_r   <= S_OUT;
          end else if (eom_r && pad_done_r) begin
            len_r   <= 1'b1;
            state_r <= S_RD;
          end else if (eom_r) begin
            state_r <= S_PAD;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_idx_r <= 2'(out_idx_r + 2'd1);
            if (out_idx_r == 2'd3) begin
              chain_r[0] <= INIT_A;
              chain_r[1] <= INIT_B;
              chain_r[2] <= INIT_C;
              chain_r[3] <= INIT_D;
              count_r    <= 64'h0;
              eom_r      <= 1'b0;
              len_r      <= 1'b0;
              state_r    <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken while digest pending");
  a_rounds_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RND && rnd_r == LAST_ROUND) |=> (state_r == S_FIN))
    else $error("round counter overran");
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.last_word) |=>
      (out_valid && out_data.word_index == 2'($past(out_data.word_index) + 2'd1)))
    else $error("digest word order broken");
  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.last_word) |=> (in_ready && count_r == 64'h0))
    else $error("engine not reset after digest");
`endif

endmodule
